>>> sv/psq_pkg.sv
// ----------------------------------------------------------------------------
// psq_pkg
// Shared constants and controller/datapath interface types for the
// priority-sorted command queue.
// ----------------------------------------------------------------------------
package psq_pkg;

  localparam int QueueDepth = 16;
  localparam int CntW       = $clog2(QueueDepth + 1);
  localparam int TagW       = 8;
  localparam int PrioW      = 8;
  localparam int CountOutW  = 5;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture the incoming transaction
    logic ins;       // insert the captured entry (or flag a drop)
    logic rem_step;  // delete the first matching entry
    logic report;    // register the result and raise the strobe
  } psq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_remove;
    logic any_match;
  } psq_sts_t;

endpackage

>>> sv/psq_ctrl.sv
// ----------------------------------------------------------------------------
// psq_ctrl
// Sequencer: accepts a transaction, runs an insert step or a run of
// remove steps, then hands the result to the output register.
// ----------------------------------------------------------------------------
module psq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  psq_pkg::psq_sts_t sts_i,
  output psq_pkg::psq_cmd_t cmd_o
);
  import psq_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StOp   = 2'd1;
  localparam logic [1:0] StRpt  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = StOp;
        end
      end
      StOp: begin
        if (!sts_i.is_remove) begin
          cmd_o.ins = 1'b1;
          state_d   = StRpt;
        end else if (sts_i.any_match) begin
          cmd_o.rem_step = 1'b1;
        end else begin
          state_d = StRpt;
        end
      end
      StRpt: begin
        cmd_o.report = 1'b1;
        state_d      = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

endmodule

>>> sv/psq_dp.sv
// ----------------------------------------------------------------------------
// psq_dp
// Slot array with parallel compare-and-shift insert, single-match
// delete step, and the registered result.
// ----------------------------------------------------------------------------
module psq_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  psq_pkg::psq_cmd_t           cmd_i,
  output psq_pkg::psq_sts_t           sts_o,
  input  logic                        action_i,
  input  logic [psq_pkg::TagW-1:0]    entry_tag_i,
  input  logic [psq_pkg::PrioW-1:0]   entry_priority_i,
  output logic                        result_valid_o,
  output logic                        head_valid_o,
  output logic [psq_pkg::TagW-1:0]    head_tag_o,
  output logic [psq_pkg::PrioW-1:0]   head_priority_o,
  output logic [psq_pkg::CountOutW-1:0] entry_count_o,
  output logic                        dropped_o
);
  import psq_pkg::*;

  logic [TagW-1:0]  slot_tag_q  [QueueDepth];
  logic [TagW-1:0]  slot_tag_d  [QueueDepth];
  logic [PrioW-1:0] slot_prio_q [QueueDepth];
  logic [PrioW-1:0] slot_prio_d [QueueDepth];
  logic [CntW-1:0]  count_q, count_d;

  logic             action_q;
  logic [TagW-1:0]  tag_q;
  logic [PrioW-1:0] prio_q;
  logic             drop_q, drop_d;

  logic [QueueDepth-1:0] valid, ge, match, prefix;
  logic full;

  logic                 res_valid_q;
  logic                 head_valid_q;
  logic [TagW-1:0]      head_tag_q;
  logic [PrioW-1:0]     head_prio_q;
  logic [CountOutW-1:0] count_out_q;
  logic [CntW+CountOutW-1:0] count_ext;

  assign full = (count_q == CntW'(QueueDepth));

  always_comb begin
    for (int i = 0; i < QueueDepth; i++) begin
      valid[i] = (CntW'(i) < count_q);
      ge[i]    = valid[i] && (prio_q <= slot_prio_q[i]);
      match[i] = valid[i] && (slot_tag_q[i] == tag_q);
    end
    prefix[0] = match[0];
    for (int i = 1; i < QueueDepth; i++) begin
      prefix[i] = prefix[i-1] | match[i];
    end
  end

  assign sts_o.is_remove = action_q;
  assign sts_o.any_match = |match;

  // Next slot contents: ge is a prefix because the slots stay sorted
  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    for (int i = 0; i < QueueDepth; i++) begin
      slot_tag_d[i]  = slot_tag_q[i];
      slot_prio_d[i] = slot_prio_q[i];
    end
    if (cmd_i.load) begin
      drop_d = 1'b0;
    end
    if (cmd_i.ins) begin
      drop_d = full;
      if (!full) begin
        count_d = count_q + CntW'(1);
        for (int i = 0; i < QueueDepth; i++) begin
          if (!ge[i]) begin
            if (i == 0) begin
              slot_tag_d[i]  = tag_q;
              slot_prio_d[i] = prio_q;
            end else if (ge[i-1]) begin
              slot_tag_d[i]  = tag_q;
              slot_prio_d[i] = prio_q;
            end else begin
              slot_tag_d[i]  = slot_tag_q[i-1];
              slot_prio_d[i] = slot_prio_q[i-1];
            end
          end
        end
      end
    end
    if (cmd_i.rem_step) begin
      count_d = count_q - CntW'(1);
      for (int i = 0; i < QueueDepth - 1; i++) begin
        if (prefix[i]) begin
          slot_tag_d[i]  = slot_tag_q[i+1];
          slot_prio_d[i] = slot_prio_q[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QueueDepth; i++) begin
      slot_tag_q[i]  <= slot_tag_d[i];
      slot_prio_q[i] <= slot_prio_d[i];
    end
    if (cmd_i.load) begin
      tag_q  <= entry_tag_i;
      prio_q <= entry_priority_i;
    end
  end

  assign count_ext = {{CountOutW{1'b0}}, count_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.report) begin
      head_valid_q <= (count_q != '0);
      head_tag_q   <= (count_q != '0) ? slot_tag_q[0]  : '0;
      head_prio_q  <= (count_q != '0) ? slot_prio_q[0] : '0;
      count_out_q  <= count_ext[CountOutW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      action_q    <= 1'b0;
      drop_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      drop_q      <= drop_d;
      res_valid_q <= cmd_i.report;
      if (cmd_i.load) begin
        action_q <= action_i;
      end
    end
  end

  // drop_q only changes on load and insert, so it is stable at the strobe
  assign result_valid_o  = res_valid_q;
  assign head_valid_o    = head_valid_q;
  assign head_tag_o      = head_tag_q;
  assign head_priority_o = head_prio_q;
  assign entry_count_o   = count_out_q;
  assign dropped_o       = drop_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("entry count above queue depth");

  a_rem_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rem_step |=> count_q == $past(count_q) - CntW'(1))
    else $error("remove step did not free one slot");

  a_ins_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.ins && !full) |=> (count_q == $past(count_q) + CntW'(1)) && !drop_q)
    else $error("insert did not take a slot");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(2)) |-> slot_prio_q[0] >= slot_prio_q[1])
    else $error("head pair out of priority order");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !head_valid_o) |-> (entry_count_o == '0))
    else $error("empty head reported with entries held");

endmodule

>>> sv/priority_sorted_command_queue_top.sv
// ----------------------------------------------------------------------------
// priority_sorted_command_queue_top
// Bounded queue of tagged entries kept sorted by priority, with insert and
// remove-by-tag transactions and a one-cycle result strobe.
// ----------------------------------------------------------------------------
// An insert runs a single insert step; a remove runs one delete step per
//   matching entry (one delete per cycle) until no match is left.
// A new transaction is taken only once the last one is done; busy drops in the strobe cycle.
// Results are never stalled: result_valid_o is high for exactly one cycle.
// Reset (rst_ni low, asynchronous) empties the queue and idles the sequencer.
module priority_sorted_command_queue_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          action_i,
  input  logic [psq_pkg::TagW-1:0]      entry_tag_i,
  input  logic [psq_pkg::PrioW-1:0]     entry_priority_i,
  output logic                          result_valid_o,
  output logic                          head_valid_o,
  output logic [psq_pkg::TagW-1:0]      head_tag_o,
  output logic [psq_pkg::PrioW-1:0]     head_priority_o,
  output logic [psq_pkg::CountOutW-1:0] entry_count_o,
  output logic                          dropped_o
);
  import psq_pkg::*;

  psq_cmd_t cmd;
  psq_sts_t sts;

  psq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  psq_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .action_i         (action_i),
    .entry_tag_i      (entry_tag_i),
    .entry_priority_i (entry_priority_i),
    .result_valid_o   (result_valid_o),
    .head_valid_o     (head_valid_o),
    .head_tag_o       (head_tag_o),
    .head_priority_o  (head_priority_o),
    .entry_count_o    (entry_count_o),
    .dropped_o        (dropped_o)
  );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the priority-sorted command queue: a directed pass
// over the corner cases, then random insert/remove traffic with sender gaps,
// each result strobe compared against a behavioural model of the sorted list.
// ----------------------------------------------------------------------------
module tb_top;
  import psq_pkg::*;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } cmd_action_e;

  typedef struct packed {
    logic                 head_valid;
    logic [TagW-1:0]      head_tag;
    logic [PrioW-1:0]     head_priority;
    logic [CountOutW-1:0] entry_count;
    logic                 dropped;
  } head_report_t;

  localparam int WatchdogLimit = 500;
  localparam int SettleCycles  = 32;
  localparam int ItemsPerPhase = 660;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic                 action_i;
  logic [TagW-1:0]      entry_tag_i;
  logic [PrioW-1:0]     entry_priority_i;
  logic                 result_valid_o;
  logic                 head_valid_o;
  logic [TagW-1:0]      head_tag_o;
  logic [PrioW-1:0]     head_priority_o;
  logic [CountOutW-1:0] entry_count_o;
  logic                 dropped_o;

  // model of the sorted list
  logic [TagW-1:0]  model_tags  [QueueDepth];
  logic [PrioW-1:0] model_prios [QueueDepth];
  int               model_count;

  head_report_t pending_reports[$];
  head_report_t seen_report;
  logic [TagW-1:0] recent_tags[$];

  int fail_count;
  int idle_cycles;
  int sender_idle_pct;
  int n_insert, n_remove, n_dropped, n_empty_reports, n_full_hits, n_checked;

  priority_sorted_command_queue_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .action_i        (action_i),
    .entry_tag_i     (entry_tag_i),
    .entry_priority_i(entry_priority_i),
    .result_valid_o  (result_valid_o),
    .head_valid_o    (head_valid_o),
    .head_tag_o      (head_tag_o),
    .head_priority_o (head_priority_o),
    .entry_count_o   (entry_count_o),
    .dropped_o       (dropped_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Applies one accepted transaction to the model and returns the expected report.
  function automatic head_report_t apply_command(cmd_action_e act, logic [TagW-1:0] tag,
                                                 logic [PrioW-1:0] prio);
    head_report_t rep;
    int pos;
    int wr;
    rep = '0;
    if (act == ACT_INSERT) begin
      if (model_count >= QueueDepth) begin
        rep.dropped = 1'b1;
      end else begin
        pos = 0;
        // equal priority goes behind what is already held
        while (pos < model_count && prio <= model_prios[pos]) pos++;
        for (int i = model_count; i > pos; i--) begin
          model_tags[i]  = model_tags[i-1];
          model_prios[i] = model_prios[i-1];
        end
        model_tags[pos]  = tag;
        model_prios[pos] = prio;
        model_count++;
      end
    end else begin
      wr = 0;
      for (int rd = 0; rd < model_count; rd++) begin
        if (model_tags[rd] != tag) begin
          model_tags[wr]  = model_tags[rd];
          model_prios[wr] = model_prios[rd];
          wr++;
        end
      end
      model_count = wr;
    end
    if (model_count > 0) begin
      rep.head_valid    = 1'b1;
      rep.head_tag      = model_tags[0];
      rep.head_priority = model_prios[0];
    end
    rep.entry_count = CountOutW'(model_count);
    return rep;
  endfunction

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // Result checker, model update on acceptance, and the stall watchdog.
  always @(posedge clk_i) begin
    if (result_valid_o) begin
      if (pending_reports.size() == 0) begin
        $error("result strobe with no transaction outstanding");
        fail_count++;
      end else begin
        seen_report = pending_reports.pop_front();
        check_field("head_valid", seen_report.head_valid, head_valid_o);
        check_field("head_tag", seen_report.head_tag, head_tag_o);
        check_field("head_priority", seen_report.head_priority, head_priority_o);
        check_field("entry_count", seen_report.entry_count, entry_count_o);
        check_field("dropped", seen_report.dropped, dropped_o);
        n_checked++;
      end
    end
    if (rst_ni && start && !busy) begin
      seen_report = apply_command(cmd_action_e'(action_i), entry_tag_i, entry_priority_i);
      pending_reports.push_back(seen_report);
      if (cmd_action_e'(action_i) == ACT_INSERT) n_insert++;
      else n_remove++;
      if (seen_report.dropped) n_dropped++;
      if (!seen_report.head_valid) n_empty_reports++;
      if (model_count == QueueDepth) n_full_hits++;
    end
    if ((rst_ni && start && !busy) || result_valid_o || !rst_ni) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no transaction for %0d cycles", idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Presents one command and returns at the edge where it is taken.
  task automatic send_cmd(cmd_action_e act, logic [TagW-1:0] tag, logic [PrioW-1:0] prio);
    int gap;
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start            <= 1'b1;
    action_i         <= act;
    entry_tag_i      <= tag;
    entry_priority_i <= prio;
    do @(posedge clk_i); while (!(start && !busy));
    if (act == ACT_INSERT) begin
      recent_tags.push_back(tag);
      if (recent_tags.size() > 32) void'(recent_tags.pop_front());
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_cases();
    sender_idle_pct = 0;
    send_cmd(ACT_REMOVE, 8'h3C, 8'h00);   // remove on empty queue
    send_cmd(ACT_INSERT, 8'h00, 8'h00);
    send_cmd(ACT_INSERT, 8'hFF, 8'hFF);
    send_cmd(ACT_INSERT, 8'hAA, 8'h80);
    send_cmd(ACT_INSERT, 8'h55, 8'h80);   // equal priority keeps arrival order
    send_cmd(ACT_INSERT, 8'hAA, 8'h7F);   // duplicate tag
    send_cmd(ACT_REMOVE, 8'h99, 8'hFF);   // absent tag
    send_cmd(ACT_REMOVE, 8'hAA, 8'h5A);   // both copies go
    for (int i = 0; i < 13; i++) begin
      send_cmd(ACT_INSERT, TagW'(i * 17 + 1), PrioW'((i % 4) * 85));
    end
    send_cmd(ACT_INSERT, 8'hFF, 8'hFF);   // full: dropped
    send_cmd(ACT_REMOVE, 8'hFF, 8'h00);
    wait_for_results();
  endtask

  task automatic test_random_traffic(int idle_pct, int n_items);
    int insert_pct;
    cmd_action_e act;
    logic [TagW-1:0] tag;
    logic [PrioW-1:0] prio;
    sender_idle_pct = idle_pct;
    insert_pct = 50;
    for (int n = 0; n < n_items; n++) begin
      // swing between filling and draining so full and empty are both reached
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0: insert_pct = 85;
          1: insert_pct = 20;
          default: insert_pct = 55;
        endcase
      end
      if (n == n_items / 2) wait_for_results();
      act = ($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
      if (act == ACT_REMOVE && recent_tags.size() > 0 && $urandom_range(99) < 75) begin
        tag = recent_tags[$urandom_range(recent_tags.size() - 1)];
      end else if ($urandom_range(1)) begin
        tag = TagW'($urandom_range(15));
      end else begin
        tag = TagW'($urandom_range(255));
      end
      if ($urandom_range(99) < 30) prio = PrioW'($urandom_range(3) * 85);
      else prio = PrioW'($urandom_range(255));
      send_cmd(act, tag, prio);
    end
    wait_for_results();
  endtask

  initial begin
    fail_count      = 0;
    idle_cycles     = 0;
    model_count     = 0;
    sender_idle_pct = 0;
    n_insert        = 0;
    n_remove        = 0;
    n_dropped       = 0;
    n_empty_reports = 0;
    n_full_hits     = 0;
    n_checked       = 0;
    for (int i = 0; i < QueueDepth; i++) begin
      model_tags[i]  = '0;
      model_prios[i] = '0;
    end
    rst_ni           <= 1'b0;
    start            <= 1'b0;
    action_i         <= ACT_INSERT;
    entry_tag_i      <= '0;
    entry_priority_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_traffic(33, ItemsPerPhase);
    test_random_traffic(50, ItemsPerPhase);
    test_random_traffic(0, ItemsPerPhase);

    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);
    $display("covered %0d inserts, %0d removes, %0d results checked", n_insert, n_remove,
             n_checked);
    $display("queue full %0d times, %0d inserts dropped, %0d reports of an empty queue",
             n_full_hits, n_dropped, n_empty_reports);
    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
